@@ hw/rtl/dlr_pkg.sv @@
`default_nettype none
package dlr_pkg;

  localparam int RasterWidthDef  = 1024;
  localparam int RasterHeightDef = 1024;

  localparam int CoordW   = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int ScaleW   = 24;
  localparam int FracW    = 16;
  localparam int ProdW    = DiffW + ScaleW;
  localparam int SumW     = ProdW + 1;
  localparam int IntW     = SumW - FracW;
  localparam int PixW     = 10;
  localparam int DashW    = 16;
  localparam int DashPosW = 4;

  localparam int InDataW  = 32;
  localparam int InUserW  = 2;
  localparam int OutDataW = 24;

  localparam int ApbDataW = 32;
  localparam int CfgAddrW = 5;
  localparam int RegIdxW  = 3;

  localparam int OutDepth  = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;
  localparam int InFlightW = 4;

  localparam logic [ScaleW-1:0] ScaleReset = 24'h010000;
  localparam logic [DashW-1:0]  DashReset  = 16'hFFFF;

  typedef enum logic [InUserW-1:0] {
    ACT_MOVE_TO = 2'd0,
    ACT_LINE_TO = 2'd1,
    ACT_STEP    = 2'd2
  } action_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_SCALE_X  = 3'd4,
    REG_SCALE_Y  = 3'd5,
    REG_DASH     = 3'd6
  } reg_e;

endpackage
`default_nettype wire

@@ hw/rtl/dlr_axis_map.sv @@
`default_nettype none
module dlr_axis_map #(
  parameter int SIZE = dlr_pkg::RasterWidthDef
) (
  input  logic                              clk_i,
  input  logic signed [dlr_pkg::CoordW-1:0] coord_i,
  input  logic signed [dlr_pkg::CoordW-1:0] origin_i,
  input  logic signed [dlr_pkg::ScaleW-1:0] scale_i,
  input  logic signed [dlr_pkg::CoordW-1:0] offset_i,
  output logic [$clog2(SIZE)-1:0]           pixel_o
);
  import dlr_pkg::*;

  localparam int OutW = $clog2(SIZE);
  localparam logic [IntW-1:0] MaxPix = IntW'(SIZE - 1);

  logic signed [DiffW-1:0] diff_w;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [SumW-1:0]  sum_w;
  logic [IntW-1:0]         int_w;

  assign diff_w = DiffW'(coord_i) - DiffW'(origin_i);
  assign prod_d = ProdW'(diff_w) * ProdW'(scale_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign sum_w = SumW'(prod_q) + (SumW'(offset_i) <<< FracW);
  assign int_w = sum_w[SumW-1:FracW];

  always_comb begin
    if (sum_w <= 0) begin
      pixel_o = '0;
    end else if (int_w > MaxPix) begin
      pixel_o = OutW'(MaxPix);
    end else begin
      pixel_o = OutW'(int_w);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/dashed_line_rasterizer.sv @@
`default_nettype none
// Dashed line rasterizer. A move_to request stores a user-space point; a line_to request
// maps the stored and the new point to device pixels and arms a Bresenham-style walk; each
// step request then yields one pixel whose dot flag follows the 16-bit dash pattern, with
// the endpoint always drawn and flagged by tlast. The block takes one request per cycle
// while s_axis_tready is high. A request passes an input register, the mapping multipliers
// and the pixel stage, where the walk advances by one pixel per cycle while step requests
// arrive; its pixel is then written to the result buffer. Results queue in a four-entry
// buffer; s_axis_tready drops once the buffered results and the requests in the two stages
// ahead of it reach four, so a stalled output stops the input before the buffer can
// overflow. Configuration registers lie at byte addresses 4*i.
module dashed_line_rasterizer #(
  parameter int RASTER_WIDTH  = dlr_pkg::RasterWidthDef,
  parameter int RASTER_HEIGHT = dlr_pkg::RasterHeightDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // coord_x [15:0], coord_y [31:16]
  input  logic [dlr_pkg::InDataW-1:0]     s_axis_tdata,
  // action [1:0]
  input  logic [dlr_pkg::InUserW-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pixel_x [9:0], pixel_y [19:10], dot [20], zero fill [23:21]
  output logic [dlr_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dlr_pkg::CfgAddrW-1:0]    paddr,
  input  logic [dlr_pkg::ApbDataW-1:0]    pwdata,
  output logic [dlr_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import dlr_pkg::*;

  localparam int XW   = $clog2(RASTER_WIDTH);
  localparam int YW   = $clog2(RASTER_HEIGHT);
  localparam int ErrW = ((XW > YW) ? XW : YW) + 3;

  typedef struct packed {
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
    logic            dot;
    logic            last;
  } result_t;

  // Configuration registers.
  logic [CoordW-1:0] origin_x_q, origin_y_q, offset_x_q, offset_y_q;
  logic [ScaleW-1:0] scale_x_q, scale_y_q;
  logic [DashW-1:0]  dash_q;
  logic              cfg_wr;
  reg_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      offset_x_q <= '0;
      offset_y_q <= '0;
      scale_x_q  <= ScaleReset;
      scale_y_q  <= ScaleReset;
      dash_q     <= DashReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X: origin_x_q <= pwdata[CoordW-1:0];
        REG_ORIGIN_Y: origin_y_q <= pwdata[CoordW-1:0];
        REG_OFFSET_X: offset_x_q <= pwdata[CoordW-1:0];
        REG_OFFSET_Y: offset_y_q <= pwdata[CoordW-1:0];
        REG_SCALE_X:  scale_x_q  <= pwdata[ScaleW-1:0];
        REG_SCALE_Y:  scale_y_q  <= pwdata[ScaleW-1:0];
        REG_DASH:     dash_q     <= pwdata[DashW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X: prdata = ApbDataW'(origin_x_q);
      REG_ORIGIN_Y: prdata = ApbDataW'(origin_y_q);
      REG_OFFSET_X: prdata = ApbDataW'(offset_x_q);
      REG_OFFSET_Y: prdata = ApbDataW'(offset_y_q);
      REG_SCALE_X:  prdata = ApbDataW'(scale_x_q);
      REG_SCALE_Y:  prdata = ApbDataW'(scale_y_q);
      REG_DASH:     prdata = ApbDataW'(dash_q);
      default:      prdata = '0;
    endcase
  end

  // Input register.
  logic              s_acc;
  logic              a_valid_q, b_valid_q;
  action_e           a_action_q, b_action_q;
  logic [CoordW-1:0] a_x_q, a_y_q;
  logic [CoordW-1:0] prev_x_q, prev_y_q;
  logic [FifoCntW-1:0] fifo_cnt_q;
  logic [InFlightW-1:0] in_flight_w;

  assign in_flight_w   = InFlightW'(fifo_cnt_q) + InFlightW'(a_valid_q)
                       + InFlightW'(b_valid_q);
  assign s_axis_tready = in_flight_w < InFlightW'(OutDepth);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else begin
      a_valid_q <= s_acc;
      b_valid_q <= a_valid_q;
      if (a_valid_q && (a_action_q == ACT_MOVE_TO || a_action_q == ACT_LINE_TO)) begin
        prev_x_q <= a_x_q;
        prev_y_q <= a_y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_action_q <= action_e'(s_axis_tuser);
    a_x_q      <= s_axis_tdata[CoordW-1:0];
    a_y_q      <= s_axis_tdata[2*CoordW-1:CoordW];
    b_action_q <= a_action_q;
  end

  // Coordinate mapping, product registered inside each unit.
  logic [XW-1:0] sx_w, ex_w;
  logic [YW-1:0] sy_w, ey_w;

  dlr_axis_map #(.SIZE(RASTER_WIDTH)) u_map_x0 (
    .clk_i, .coord_i(prev_x_q), .origin_i(origin_x_q), .scale_i(scale_x_q),
    .offset_i(offset_x_q), .pixel_o(sx_w)
  );
  dlr_axis_map #(.SIZE(RASTER_WIDTH)) u_map_x1 (
    .clk_i, .coord_i(a_x_q), .origin_i(origin_x_q), .scale_i(scale_x_q),
    .offset_i(offset_x_q), .pixel_o(ex_w)
  );
  dlr_axis_map #(.SIZE(RASTER_HEIGHT)) u_map_y0 (
    .clk_i, .coord_i(prev_y_q), .origin_i(origin_y_q), .scale_i(scale_y_q),
    .offset_i(offset_y_q), .pixel_o(sy_w)
  );
  dlr_axis_map #(.SIZE(RASTER_HEIGHT)) u_map_y1 (
    .clk_i, .coord_i(a_y_q), .origin_i(origin_y_q), .scale_i(scale_y_q),
    .offset_i(offset_y_q), .pixel_o(ey_w)
  );

  // Walk state.
  logic [XW-1:0]         cur_px_q, cur_px_d, end_px_q, end_px_d, span_x_q, span_x_d;
  logic [YW-1:0]         cur_py_q, cur_py_d, end_py_q, end_py_d, span_y_q, span_y_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic                  step_left_q, step_left_d, step_up_q, step_up_d;
  logic                  walking_q, walking_d;
  logic [DashPosW-1:0]   pos_q, pos_d;

  logic signed [ErrW-1:0] ey_ext, exn_ext, e1_w, e2_w, e3_w, a1_w, a2_w, a3_w;
  logic                  at_end, diag, xonly, push;
  logic [XW-1:0]         nx_w;
  logic [YW-1:0]         ny_w;
  result_t               res_w;

  assign ey_ext  = $signed(ErrW'(span_y_q));
  assign exn_ext = -$signed(ErrW'(span_x_q));
  assign e1_w    = err_q + ey_ext;
  assign e2_w    = err_q + exn_ext;
  assign e3_w    = e1_w + exn_ext;
  assign a1_w    = e1_w[ErrW-1] ? -e1_w : e1_w;
  assign a2_w    = e2_w[ErrW-1] ? -e2_w : e2_w;
  assign a3_w    = e3_w[ErrW-1] ? -e3_w : e3_w;
  assign at_end  = (cur_px_q == end_px_q) && (cur_py_q == end_py_q);
  assign nx_w    = step_left_q ? cur_px_q - XW'(1) : cur_px_q + XW'(1);
  assign ny_w    = step_up_q ? cur_py_q - YW'(1) : cur_py_q + YW'(1);

  always_comb begin
    if (a1_w < a2_w) begin
      diag  = a3_w < a1_w;
      xonly = !diag;
    end else begin
      diag  = a3_w < a2_w;
      xonly = 1'b0;
    end
  end

  always_comb begin
    cur_px_d    = cur_px_q;
    cur_py_d    = cur_py_q;
    end_px_d    = end_px_q;
    end_py_d    = end_py_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    err_d       = err_q;
    step_left_d = step_left_q;
    step_up_d   = step_up_q;
    walking_d   = walking_q;
    pos_d       = pos_q;
    push        = 1'b0;
    res_w.x     = PixW'(cur_px_q);
    res_w.y     = PixW'(cur_py_q);
    res_w.dot   = at_end ? 1'b1 : dash_q[pos_q];
    res_w.last  = at_end;
    if (b_valid_q) begin
      if (b_action_q == ACT_LINE_TO) begin
        cur_px_d    = sx_w;
        cur_py_d    = sy_w;
        end_px_d    = ex_w;
        end_py_d    = ey_w;
        span_x_d    = (ex_w >= sx_w) ? ex_w - sx_w : sx_w - ex_w;
        span_y_d    = (ey_w >= sy_w) ? ey_w - sy_w : sy_w - ey_w;
        step_left_d = sx_w > ex_w;
        step_up_d   = sy_w > ey_w;
        err_d       = '0;
        walking_d   = 1'b1;
      end else if (b_action_q != ACT_MOVE_TO && walking_q) begin
        push = 1'b1;
        if (at_end) begin
          walking_d = 1'b0;
        end else begin
          pos_d = pos_q + DashPosW'(1);
          if (diag) begin
            cur_px_d = nx_w;
            cur_py_d = ny_w;
            err_d    = e3_w;
          end else if (xonly) begin
            cur_px_d = nx_w;
            err_d    = e1_w;
          end else begin
            cur_py_d = ny_w;
            err_d    = e2_w;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_px_q    <= '0;
      cur_py_q    <= '0;
      end_px_q    <= '0;
      end_py_q    <= '0;
      span_x_q    <= '0;
      span_y_q    <= '0;
      err_q       <= '0;
      step_left_q <= 1'b0;
      step_up_q   <= 1'b0;
      walking_q   <= 1'b0;
      pos_q       <= '0;
    end else begin
      cur_px_q    <= cur_px_d;
      cur_py_q    <= cur_py_d;
      end_px_q    <= end_px_d;
      end_py_q    <= end_py_d;
      span_x_q    <= span_x_d;
      span_y_q    <= span_y_d;
      err_q       <= err_d;
      step_left_q <= step_left_d;
      step_up_q   <= step_up_d;
      walking_q   <= walking_d;
      pos_q       <= pos_d;
    end
  end

  // Result buffer.
  result_t             fifo_q [OutDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic                pop;
  result_t             head_w;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign head_w        = fifo_q[rd_ptr_q];
  assign m_axis_tdata  = OutDataW'({head_w.dot, head_w.y, head_w.x});
  assign m_axis_tlast  = head_w.last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FifoCntW'(push) - FifoCntW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/dlr_checker.sv @@
`default_nettype none
module dlr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dlr_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [dlr_pkg::CfgAddrW-1:0]  paddr,
  input logic [dlr_pkg::ApbDataW-1:0]  pwdata,
  input logic [dlr_pkg::ApbDataW-1:0]  prdata,
  input logic                          pready
);
  import dlr_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  // The input side only stalls while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // A dash pattern write is visible to a read in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr == {REG_DASH, 2'b00}) |=>
      (!(psel && !pwrite && paddr == {REG_DASH, 2'b00}) ||
       prdata[DashW-1:0] == $past(pwdata[DashW-1:0])))
    else $error("dash pattern readback mismatch");

endmodule

bind dashed_line_rasterizer dlr_checker u_dlr_checker (.*);
`default_nettype wire
